/* rtl/core/bitmap_range_set_clear_find_defines.svh */
// ----------------------------------------------------------------------------
// bitmap range set/clear/find - assertion macros
// shared assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef BITMAP_RANGE_SET_CLEAR_FIND_DEFINES_SVH
`define BITMAP_RANGE_SET_CLEAR_FIND_DEFINES_SVH

// same-cycle implication, masked during reset
`define BRSC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define BRSC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, checked through reset as well
`define BRSC_ASSERT_NXT_ALL(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/brsc_pkg.sv */
// ----------------------------------------------------------------------------
// brsc_pkg
// types, field widths and codes shared by the bitmap block
// ----------------------------------------------------------------------------
`default_nettype none

package brsc_pkg;

  localparam int WORD_BITS_DEF = 64;
  localparam int NUM_WORDS_DEF = 64;

  localparam int FUNC_W   = 2;
  localparam int START_W  = 12;
  localparam int COUNT_W  = 13;
  localparam int POS_W    = 13;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 7;

  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 16;

  localparam logic [CFG_W-1:0] WIU_RESET = 7'd64;

  typedef enum logic [FUNC_W-1:0] {
    FN_SET       = 2'd0,
    FN_CLEAR     = 2'd1,
    FN_FIND_ZERO = 2'd2,
    FN_FIND_ONE  = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_RANGE     = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOCATE,
    S_SCAN,
    S_RESULT
  } state_t;

  typedef enum logic [1:0] {
    RK_OK,
    RK_RANGE,
    RK_MISS,
    RK_HIT
  } res_kind_t;

  typedef struct packed {
    logic      clr_step;
    logic      load;
    logic      locate_step;
    logic      scan;
    logic      res_load;
    res_kind_t res_kind;
    logic      emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_find;
    logic in_range_err;
    logic in_zero;
    logic is_find;
    logic loc_done;
    logic ptr_exhausted;
    logic stage_hit;
    logic scan_done;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/core/brsc_ctrl.sv */
// ----------------------------------------------------------------------------
// brsc_ctrl
// request sequencer: clearing pass, locate, word scan and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module brsc_ctrl
  import brsc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire dp_stat_t  stat,
  output ctrl_cmd_t      cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (stat.in_range_err || (!stat.in_find && stat.in_zero)) begin
            state_next = S_RESULT;
          end else begin
            state_next = S_LOCATE;
          end
        end
      end
      S_LOCATE: begin
        if (stat.loc_done) state_next = stat.ptr_exhausted ? S_RESULT : S_SCAN;
      end
      S_SCAN: begin
        if (stat.stage_hit || stat.scan_done) state_next = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.in_range_err) begin
            cmd.res_load = 1'b1;
            cmd.res_kind = RK_RANGE;
          end else if (!stat.in_find && stat.in_zero) begin
            cmd.res_load = 1'b1;
            cmd.res_kind = RK_OK;
          end
        end
      end
      S_LOCATE: begin
        cmd.locate_step = 1'b1;
        if (stat.loc_done && stat.ptr_exhausted) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = stat.is_find ? RK_MISS : RK_OK;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.stage_hit) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RK_HIT;
        end else if (stat.scan_done) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = stat.is_find ? RK_MISS : RK_OK;
        end
      end
      S_RESULT: begin
        cmd.emit = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/brsc_dpath.sv */
// ----------------------------------------------------------------------------
// brsc_dpath
// bitmap memory, word pointer, per-word mask/search stage and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module brsc_dpath
  import brsc_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int NUM_WORDS = NUM_WORDS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [CFG_W-1:0]   cfg_wdata,
  input  wire func_t              in_func,
  input  wire logic [START_W-1:0] in_start,
  input  wire logic [COUNT_W-1:0] in_count,
  input  wire ctrl_cmd_t          cmd,
  output dp_stat_t                stat,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [POS_W-1:0]        out_pos,
  output status_t                 out_status
);

  localparam int TOTAL_BITS = NUM_WORDS * WORD_BITS;
  localparam int TB_W       = $clog2(TOTAL_BITS + 1) + 1;
  localparam int BIT_W      = (TB_W > 14) ? TB_W : 14;
  localparam int ADDR_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int WIDX_W     = $clog2(NUM_WORDS + 1);
  localparam int WCMP_W     = (WIDX_W > CFG_W) ? WIDX_W : CFG_W;
  localparam int OFF_W      = $clog2(WORD_BITS + 1);
  localparam int IDX_W      = $clog2(WORD_BITS);

  localparam logic [BIT_W-1:0]  TOTAL_V = BIT_W'(TOTAL_BITS);
  localparam logic [BIT_W-1:0]  WB_V    = BIT_W'(WORD_BITS);
  localparam logic [ADDR_W-1:0] LAST_A  = ADDR_W'(NUM_WORDS - 1);

  logic [WORD_BITS-1:0] mem [NUM_WORDS];

  logic [CFG_W-1:0]     words_in_use;
  logic [ADDR_W-1:0]    clr_addr;

  func_t                func_q;
  logic [START_W-1:0]   start_q;
  logic [BIT_W-1:0]     end_q;
  logic [BIT_W-1:0]     stop_q;
  logic [BIT_W-1:0]     limit_q;

  logic [ADDR_W-1:0]    ptr_addr;
  logic [BIT_W-1:0]     ptr_base;

  logic                 stage_vld;
  logic [ADDR_W-1:0]    stage_addr;
  logic [BIT_W-1:0]     stage_base;
  logic [WORD_BITS-1:0] rdata;

  logic [BIT_W-1:0]     res_pos;
  status_t              res_status;

  logic [WCMP_W-1:0]    wiu_ext;
  logic [WCMP_W-1:0]    eff_words;
  logic [BIT_W-1:0]     limit_calc;
  logic [BIT_W-1:0]     in_end;
  logic                 in_find;
  logic                 is_find;
  logic                 want;
  logic [BIT_W-1:0]     start_ext;
  logic                 adv;
  logic                 issue;
  logic                 loc_step;

  logic [OFF_W-1:0]     lo;
  logic [OFF_W-1:0]     hi;
  logic [OFF_W-1:0]     hi_eff;
  logic [WORD_BITS-1:0] rng;
  logic [WORD_BITS-1:0] cand;
  logic [WORD_BITS-1:0] wmask;
  logic [WORD_BITS-1:0] lowest;
  logic [IDX_W-1:0]     hit_idx;
  logic [IDX_W-1:0]     j_idx;
  logic                 stage_hit;
  logic [BIT_W-1:0]     hit_pos;

  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 out_free;

  // request decode and limits
  assign wiu_ext    = WCMP_W'(words_in_use);
  assign eff_words  = (wiu_ext > WCMP_W'(NUM_WORDS)) ? WCMP_W'(NUM_WORDS) : wiu_ext;
  assign limit_calc = BIT_W'(eff_words) * WB_V;
  assign in_end     = BIT_W'(in_start) + BIT_W'(in_count);
  assign in_find    = (in_func == FN_FIND_ZERO) || (in_func == FN_FIND_ONE);
  assign is_find    = (func_q == FN_FIND_ZERO) || (func_q == FN_FIND_ONE);
  assign want       = (func_q == FN_FIND_ONE);
  assign start_ext  = BIT_W'(start_q);

  // word pointer: walks to the word holding start, then issues reads
  assign adv      = ((ptr_base + WB_V) <= start_ext) && (ptr_base < stop_q);
  assign issue    = (ptr_base < stop_q) && !stage_hit;
  assign loc_step = cmd.locate_step && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      words_in_use <= WIU_RESET;
    end else if (cfg_we) begin
      words_in_use <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q  <= in_func;
      start_q <= in_start;
      end_q   <= in_end;
      limit_q <= limit_calc;
      stop_q  <= in_find ? limit_calc : in_end;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ptr_addr <= '0;
      ptr_base <= '0;
    end else if (loc_step || (cmd.scan && issue)) begin
      ptr_addr <= ptr_addr + ADDR_W'(1);
      ptr_base <= ptr_base + WB_V;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld <= 1'b0;
    end else begin
      stage_vld <= cmd.scan && issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && issue) begin
      stage_addr <= ptr_addr;
      stage_base <= ptr_base;
    end
  end

  // memory: one registered read, one write per cycle
  always_ff @(posedge clk) begin
    if (cmd.scan && issue) begin
      rdata <= mem[ptr_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // per-word window: offsets counted from the msb of the word
  always_comb begin
    lo     = (start_ext > stage_base) ? OFF_W'(start_ext - stage_base) : '0;
    hi     = (end_q >= (stage_base + WB_V)) ? OFF_W'(WORD_BITS) : OFF_W'(end_q - stage_base);
    hi_eff = is_find ? OFF_W'(WORD_BITS) : hi;
    for (int j = 0; j < WORD_BITS; j++) begin
      rng[j]                 = (OFF_W'(j) >= lo) && (OFF_W'(j) < hi_eff);
      cand[j]                = rng[j] && (rdata[WORD_BITS-1-j] == want);
      wmask[WORD_BITS-1-j]   = rng[j];
    end
  end

  // lowest candidate offset: isolate the lowest set bit, then encode
  assign lowest = cand & (~cand + WORD_BITS'(1));

  always_comb begin
    hit_idx = '0;
    j_idx   = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      j_idx = IDX_W'(j);
      for (int k = 0; k < IDX_W; k++) begin
        hit_idx[k] = hit_idx[k] | (lowest[j] & j_idx[k]);
      end
    end
  end

  assign stage_hit = stage_vld && is_find && (|cand);
  assign hit_pos   = stage_base + BIT_W'(hit_idx);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = stage_addr;
    mem_wdata = (func_q == FN_SET) ? (rdata | wmask) : (rdata & ~wmask);
    if (cmd.clr_step) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (stage_vld && !is_find) begin
      mem_we = 1'b1;
    end
  end

  // pending result and output register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_kind)
        RK_OK: begin
          res_pos    <= '0;
          res_status <= ST_OK;
        end
        RK_RANGE: begin
          res_pos    <= '0;
          res_status <= ST_RANGE;
        end
        RK_MISS: begin
          res_pos    <= limit_q;
          res_status <= ST_NOT_FOUND;
        end
        RK_HIT: begin
          res_pos    <= hit_pos;
          res_status <= ST_OK;
        end
        default: begin
          res_pos    <= '0;
          res_status <= ST_OK;
        end
      endcase
    end
  end

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_pos    <= res_pos[POS_W-1:0];
      out_status <= res_status;
    end
  end

  always_comb begin
    stat               = '0;
    stat.clr_last      = (clr_addr == LAST_A);
    stat.in_find       = in_find;
    stat.in_range_err  = !in_find && (in_end > TOTAL_V);
    stat.in_zero       = (in_count == '0);
    stat.is_find       = is_find;
    stat.loc_done      = !adv;
    stat.ptr_exhausted = (ptr_base >= stop_q);
    stat.stage_hit     = stage_hit;
    stat.scan_done     = !stage_vld && (ptr_base >= stop_q);
    stat.out_free      = out_free;
  end

endmodule

`default_nettype wire

/* rtl/core/bitmap_range_set_clear_find.sv */
// ----------------------------------------------------------------------------
// bitmap_range_set_clear_find
// bitmap store with range set/clear and first-zero / first-one search
// ----------------------------------------------------------------------------
// The block holds NUM_WORDS words of WORD_BITS bits in one memory; bit 0 is
// the msb of word 0. Each input item is one request: set or clear a run of
// bit_count bits from start_bit, or search upward from start_bit for the first
// 0 or 1 within the first words_in_use words. Every item gives exactly one
// result item. After reset a clearing pass writes zeros to the memory, one
// word per cycle, so the input is held off (tready low) until the pass is done.
// Requests run one at a time: after the accept, the pointer steps one word per
// cycle up to the word holding start_bit, then the scan handles one word per
// cycle with a read stage ahead of the mask/search stage, and the result is
// then handed to the output register. A rejected range or a zero-length run
// skips the locate and scan steps and goes straight to the result.
// The output register lets a new item in while the previous result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_range_set_clear_find
  import brsc_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,   // bits per memory word
  parameter int NUM_WORDS = NUM_WORDS_DEF    // words in the bitmap
) (
  input  wire logic                 clk,
  input  wire logic                 rst,

  // words_in_use register, written whenever cfg_we is high
  input  wire logic                 cfg_we,
  input  wire logic [CFG_W-1:0]     cfg_wdata,

  // request stream
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // start_bit[11:0], bit_count[24:12]
  input  wire logic [FUNC_W-1:0]    s_axis_tuser,  // func[1:0]

  // result stream
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0]      m_axis_tdata,  // position[12:0]
  output logic [STATUS_W-1:0]       m_axis_tuser   // status[1:0]
);

  ctrl_cmd_t          cmd;
  dp_stat_t           stat;
  func_t              in_func;
  logic [START_W-1:0] in_start;
  logic [COUNT_W-1:0] in_count;
  logic [POS_W-1:0]   out_pos;
  status_t            out_status;

  // unpack the request fields
  assign in_func  = func_t'(s_axis_tuser);
  assign in_start = s_axis_tdata[START_W-1:0];
  assign in_count = s_axis_tdata[START_W+COUNT_W-1:START_W];

  // sequencer: clearing pass, locate, scan, result hand-off
  brsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // memory, pointer, per-word stage and output register
  brsc_dpath #(
    .WORD_BITS (WORD_BITS),
    .NUM_WORDS (NUM_WORDS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_func    (in_func),
    .in_start   (in_start),
    .in_count   (in_count),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_pos    (out_pos),
    .out_status (out_status)
  );

  // pack the result, zero fill to the 16-bit tdata width
  assign m_axis_tdata = M_TDATA_W'(out_pos);
  assign m_axis_tuser = out_status;

endmodule

`default_nettype wire

/* rtl/core/brsc_chk.sv */
// ----------------------------------------------------------------------------
// brsc_chk
// port-level checks for the bitmap block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "bitmap_range_set_clear_find_defines.svh"

module brsc_chk
  import brsc_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 cfg_we,
  input wire logic [CFG_W-1:0]     cfg_wdata,
  input wire logic                 s_axis_tvalid,
  input wire logic                 s_axis_tready,
  input wire logic [S_TDATA_W-1:0] s_axis_tdata,
  input wire logic [FUNC_W-1:0]    s_axis_tuser,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [M_TDATA_W-1:0] m_axis_tdata,
  input wire logic [STATUS_W-1:0]  m_axis_tuser
);

  // a stalled result holds its value
  `BRSC_ASSERT_NXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // one request in flight: no accept in the cycle after an accept
  `BRSC_ASSERT_NXT(a_one_in_flight, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while another is in flight")

  // a rejected range reports position zero
  `BRSC_ASSERT_IMP(a_range_pos, clk, rst, m_axis_tvalid && (m_axis_tuser == ST_RANGE), m_axis_tdata[POS_W-1:0] == '0, "range error with nonzero position")

  // clearing pass holds off requests right after reset
  `BRSC_ASSERT_NXT_ALL(a_clear_after_rst, clk, rst, !s_axis_tready, "request port open during clearing pass")

endmodule

bind bitmap_range_set_clear_find brsc_chk u_brsc_chk (
  .clk           (clk),
  .rst           (rst),
  .cfg_we        (cfg_we),
  .cfg_wdata     (cfg_wdata),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
